// ===== rtl/wbbe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbbe_pkg
// Shared types and constants of the windowed bitrate Bayesian estimator.
// ----------------------------------------------------------------------------
package wbbe_pkg;

  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 24;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_INITIAL_WINDOW = 3'd0,
    CFG_NORMAL_WINDOW  = 3'd1,
    CFG_BASE_SCALE     = 3'd2,
    CFG_SMALL_SCALE    = 3'd3,
    CFG_LOW_USE_SCALE  = 3'd4,
    CFG_SYMMETRY_CAP   = 3'd5,
    CFG_FLOOR          = 3'd6,
    CFG_SMALL_BYTES    = 3'd7
  } cfg_idx_t;

  localparam logic FUNC_REPORT = 1'b0;
  localparam logic FUNC_HINT = 1'b1;

  localparam logic [9:0] WIN_MIN = 10'd150;
  localparam logic [9:0] WIN_MAX = 10'd1000;
  localparam logic [9:0] INITIAL_WINDOW_RST = 10'd500;
  localparam logic [9:0] NORMAL_WINDOW_RST = 10'd150;
  localparam logic [15:0] SCALE_RST = 16'd2560;

  localparam logic [31:0] VAR_RST = 32'd3276800;     // 50.0 in Q16.16
  localparam logic [31:0] PRED_ADD = 32'd327680;     // 5.0 in Q16.16
  localparam logic [31:0] HINT_ADD = 32'd13107200;   // 200.0 in Q16.16
  localparam logic [31:0] PEEK_MUL = 32'd1000;
  localparam logic [31:0] U32_MAX = 32'hFFFF_FFFF;

  typedef enum logic [4:0] {
    S_IDLE, S_TIME, S_MODW, S_CHK, S_RATE, S_B0, S_B1, S_B2, S_U, S_SQ,
    S_PRED, S_NMUL, S_NDIV, S_NE, S_VDIV, S_VAR, S_PMUL, S_PDIV, S_PEEK,
    S_DONE, S_DIV
  } state_t;

endpackage

// ===== rtl/wbbe_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbbe_in_if
// Input item channel: packet reports and fast-change hints.
// ----------------------------------------------------------------------------
interface wbbe_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] now_ms;
  logic [15:0] byte_count;
  logic        in_low_usage;
  modport source (output valid, func, now_ms, byte_count, in_low_usage, input ready);
  modport sink (input valid, func, now_ms, byte_count, in_low_usage, output ready);
endinterface

// ===== rtl/wbbe_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbbe_out_if
// Result item channel: estimate and window peek.
// ----------------------------------------------------------------------------
interface wbbe_out_if;
  logic        valid;
  logic        ready;
  logic        estimate_valid;
  logic [31:0] estimate_kbps;
  logic        sample_taken;
  logic        peek_valid;
  logic [31:0] peek_bytes_per_sec;
  modport source (output valid, estimate_valid, estimate_kbps, sample_taken, peek_valid,
                  peek_bytes_per_sec, input ready);
  modport sink (input valid, estimate_valid, estimate_kbps, sample_taken, peek_valid,
                peek_bytes_per_sec, output ready);
endinterface

// ===== rtl/wbbe_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbbe_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface wbbe_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/windowed_bitrate_bayes_estimator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_bitrate_bayes_estimator_top
// Windowed byte counter with a fixed-point Bayesian bitrate update.
// ----------------------------------------------------------------------------
// One item is in work at a time; in_ch.ready is high only while idle. The
// datapath uses a shared restoring divider that yields one quotient bit per
// cycle, plus one 32x32 multiplier with a registered product. A hint adds to
// the variance, then runs the peek division unless the window is empty. A
// report updates the window, with a modulo division when a long gap forces
// it, a rate division when a window closes, and a Bayesian update when an
// estimate already exists, then the same peek division. A finished result
// waits in the output register; the next item is accepted as soon as the
// result is loaded there, and the block holds in its last step while that
// register is still full.
// Configuration writes are taken on any cycle and must only be made while idle.
module windowed_bitrate_bayes_estimator_top (
  input  logic       clk,
  input  logic       rst_n,
  wbbe_in_if.sink    in_ch,
  wbbe_out_if.source out_ch,
  wbbe_cfg_if.sink   cfg_ch
);
  import wbbe_pkg::*;

  // configuration
  logic [9:0]  init_win_r, norm_win_r;
  logic [15:0] base_scale_r, small_scale_r, low_scale_r, small_bytes_r;
  logic [23:0] cap_r, floor_r;

  // estimator state
  state_t      state_r, state_nxt;
  logic        last_valid_r, last_valid_nxt;
  logic [31:0] last_time_r, last_time_nxt;
  logic [31:0] bytes_r, bytes_nxt;
  logic [10:0] elapsed_r, elapsed_nxt;
  logic        have_est_r, have_est_nxt;
  logic [31:0] est_r, est_nxt;
  logic [31:0] var_r, var_nxt;

  // item and working registers
  logic        func_r, low_use_r;
  logic [31:0] now_r;
  logic [15:0] bin_r;
  logic [9:0]  win_r, win_nxt;
  logic        sample_r, sample_nxt;
  logic        small_r, small_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic        below_r, below_nxt;
  logic [15:0] scale_r, scale_nxt;
  logic [31:0] diff_r, diff_nxt;
  logic [32:0] den_r, den_nxt;
  logic [31:0] svar_r, svar_nxt;
  logic [31:0] pred_r, pred_nxt;
  logic [32:0] dsum_r, dsum_nxt;
  logic [31:0] peek_r, peek_nxt;

  // shared multiplier
  logic        mul_en;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod_r;

  // shared divider
  logic        dv_go;
  logic [63:0] dv_num_r, dv_num_ld;
  logic [32:0] dv_den_r, dv_den_ld;
  logic [6:0]  dv_cnt_r, dv_cnt_ld;
  state_t      dv_ret_r, dv_ret_ld;
  logic [33:0] dv_rem_r, rem_sh, rem_new;
  logic [63:0] dv_q_r;
  logic        dv_ge;

  // output register
  logic        out_valid_r, out_est_valid_r, out_sample_r, out_peek_valid_r;
  logic [31:0] out_est_r, out_peek_r;
  logic        load_out;

  // combinational helpers
  logic [9:0]  win_raw, win_clamp;
  logic [31:0] gap;
  logic [32:0] span;
  logic        backwards;
  logic [32:0] bsum;
  logic [32:0] vsum;
  logic [31:0] cap_q8, cap_min, fl_q8;
  logic [32:0] ne_sum;
  logic [31:0] ne_val;
  logic        in_acc;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign win_raw = have_est_r ? norm_win_r : init_win_r;
  assign win_clamp = (win_raw < WIN_MIN) ? WIN_MIN : ((win_raw > WIN_MAX) ? WIN_MAX : win_raw);
  assign gap = now_r - last_time_r;
  assign span = {22'd0, elapsed_r} + {1'b0, gap};
  assign backwards = last_valid_r && (now_r < last_time_r);
  assign cap_q8 = {cap_r, 8'd0};
  assign cap_min = (rate_r < cap_q8) ? rate_r : cap_q8;
  assign fl_q8 = {floor_r, 8'd0};
  assign ne_sum = (below_r ? {1'b0, rate_r} : {1'b0, est_r}) + {1'b0, dv_q_r[31:0]};
  assign ne_val = ne_sum[32] ? U32_MAX : ne_sum[31:0];

  assign rem_sh = {dv_rem_r[32:0], dv_num_r[63]};
  assign dv_ge = rem_sh >= {1'b0, dv_den_r};
  assign rem_new = dv_ge ? (rem_sh - {1'b0, dv_den_r}) : rem_sh;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_TIME;
      S_TIME: begin
        if (func_r == FUNC_HINT) state_nxt = S_PMUL;
        else if (last_valid_r && !backwards && (gap > {22'd0, win_r})) state_nxt = S_DIV;
        else state_nxt = S_CHK;
      end
      S_MODW: state_nxt = S_CHK;
      S_CHK: state_nxt = (elapsed_r >= {1'b0, win_r}) ? S_DIV : S_PMUL;
      S_RATE: state_nxt = have_est_r ? S_B0 : S_PMUL;
      S_B0: state_nxt = S_B1;
      S_B1: state_nxt = S_B2;
      S_B2: state_nxt = (den_r == 33'd0) ? S_PRED : S_DIV;
      S_U: state_nxt = (|dv_q_r[63:24]) ? S_PRED : S_SQ;
      S_SQ: state_nxt = S_PRED;
      S_PRED: state_nxt = S_NMUL;
      S_NMUL: state_nxt = S_NDIV;
      S_NDIV: state_nxt = S_DIV;
      S_NE: state_nxt = S_VDIV;
      S_VDIV: state_nxt = S_DIV;
      S_VAR: state_nxt = S_PMUL;
      S_PMUL: state_nxt = (elapsed_r == 11'd0) ? S_DONE : S_PDIV;
      S_PDIV: state_nxt = S_DIV;
      S_PEEK: state_nxt = S_DONE;
      S_DONE: if (!out_valid_r || out_ch.ready) state_nxt = S_IDLE;
      S_DIV: if (dv_cnt_r == 7'd1) state_nxt = dv_ret_r;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and unit control
  always_comb begin
    last_valid_nxt = last_valid_r;
    last_time_nxt = last_time_r;
    bytes_nxt = bytes_r;
    elapsed_nxt = elapsed_r;
    have_est_nxt = have_est_r;
    est_nxt = est_r;
    var_nxt = var_r;
    win_nxt = win_r;
    sample_nxt = sample_r;
    small_nxt = small_r;
    rate_nxt = rate_r;
    below_nxt = below_r;
    scale_nxt = scale_r;
    diff_nxt = diff_r;
    den_nxt = den_r;
    svar_nxt = svar_r;
    pred_nxt = pred_r;
    dsum_nxt = dsum_r;
    peek_nxt = peek_r;
    mul_en = 1'b0;
    mul_a = 32'd0;
    mul_b = 32'd0;
    dv_go = 1'b0;
    dv_num_ld = 64'd0;
    dv_den_ld = 33'd0;
    dv_cnt_ld = 7'd0;
    dv_ret_ld = S_IDLE;
    load_out = 1'b0;
    bsum = 33'd0;
    vsum = {1'b0, var_r} + {1'b0, HINT_ADD};
    unique case (state_r)
      S_IDLE: begin
        sample_nxt = 1'b0;
        win_nxt = win_clamp;
      end
      S_TIME: begin
        if (func_r == FUNC_HINT) begin
          var_nxt = vsum[32] ? U32_MAX : vsum[31:0];
        end else begin
          if (backwards) begin
            bytes_nxt = 32'd0;
            elapsed_nxt = 11'd0;
          end else if (last_valid_r) begin
            if (gap > {22'd0, win_r}) begin
              bytes_nxt = 32'd0;
              dv_go = 1'b1;
              dv_num_ld = {span, 31'd0};
              dv_den_ld = {23'd0, win_r};
              dv_cnt_ld = 7'd33;
              dv_ret_ld = S_MODW;
            end else begin
              elapsed_nxt = span[10:0];
            end
          end
          last_time_nxt = now_r;
          last_valid_nxt = 1'b1;
        end
      end
      S_MODW: elapsed_nxt = dv_rem_r[10:0];
      S_CHK: begin
        if (elapsed_r >= {1'b0, win_r}) begin
          sample_nxt = 1'b1;
          small_nxt = bytes_r < {16'd0, small_bytes_r};
          elapsed_nxt = elapsed_r - {1'b0, win_r};
          bytes_nxt = {16'd0, bin_r};
          dv_go = 1'b1;
          dv_num_ld = {bytes_r, 32'd0};
          dv_den_ld = {23'd0, win_r};
          dv_cnt_ld = 7'd43;
          dv_ret_ld = S_RATE;
        end else begin
          bsum = {1'b0, bytes_r} + {17'd0, bin_r};
          bytes_nxt = bsum[32] ? U32_MAX : bsum[31:0];
        end
      end
      S_RATE: begin
        rate_nxt = (|dv_q_r[63:32]) ? U32_MAX : dv_q_r[31:0];
        if (!have_est_r) begin
          est_nxt = (|dv_q_r[63:32]) ? U32_MAX : dv_q_r[31:0];
          have_est_nxt = 1'b1;
        end
      end
      S_B0: begin
        below_nxt = rate_r < est_r;
        diff_nxt = (rate_r < est_r) ? (est_r - rate_r) : (rate_r - est_r);
        den_nxt = {1'b0, est_r} + {1'b0, cap_min};
        if (small_r && (rate_r < est_r)) scale_nxt = small_scale_r;
        else if (low_use_r && (rate_r < est_r)) scale_nxt = low_scale_r;
        else scale_nxt = base_scale_r;
      end
      S_B1: begin
        mul_en = 1'b1;
        mul_a = {16'd0, scale_r};
        mul_b = diff_r;
      end
      S_B2: begin
        if (den_r == 33'd0) begin
          svar_nxt = (diff_r == 32'd0) ? 32'd0 : U32_MAX;
        end else begin
          dv_go = 1'b1;
          dv_num_ld = {prod_r[47:0], 16'd0};
          dv_den_ld = den_r;
          dv_cnt_ld = 7'd56;
          dv_ret_ld = S_U;
        end
      end
      S_U: begin
        if (|dv_q_r[63:24]) begin
          svar_nxt = U32_MAX;
        end else begin
          mul_en = 1'b1;
          mul_a = {8'd0, dv_q_r[23:0]};
          mul_b = {8'd0, dv_q_r[23:0]};
        end
      end
      S_SQ: svar_nxt = prod_r[47:16];
      S_PRED: begin
        vsum = {1'b0, var_r} + {1'b0, PRED_ADD};
        pred_nxt = vsum[32] ? U32_MAX : vsum[31:0];
      end
      S_NMUL: begin
        dsum_nxt = {1'b0, svar_r} + {1'b0, pred_r};
        mul_en = 1'b1;
        mul_a = below_r ? svar_r : pred_r;
        mul_b = diff_r;
      end
      S_NDIV: begin
        dv_go = 1'b1;
        dv_num_ld = prod_r;
        dv_den_ld = dsum_r;
        dv_cnt_ld = 7'd64;
        dv_ret_ld = S_NE;
      end
      S_NE: begin
        // equal rates leave diff at zero, so either base gives the same sum
        est_nxt = (ne_val < fl_q8) ? fl_q8 : ne_val;
        mul_en = 1'b1;
        mul_a = svar_r;
        mul_b = pred_r;
      end
      S_VDIV: begin
        dv_go = 1'b1;
        dv_num_ld = prod_r;
        dv_den_ld = dsum_r;
        dv_cnt_ld = 7'd64;
        dv_ret_ld = S_VAR;
      end
      S_VAR: var_nxt = (|dv_q_r[63:32]) ? U32_MAX : dv_q_r[31:0];
      S_PMUL: begin
        peek_nxt = 32'd0;
        mul_en = 1'b1;
        mul_a = bytes_r;
        mul_b = PEEK_MUL;
      end
      S_PDIV: begin
        dv_go = 1'b1;
        dv_num_ld = {prod_r[41:0], 22'd0};
        dv_den_ld = {22'd0, elapsed_r};
        dv_cnt_ld = 7'd42;
        dv_ret_ld = S_PEEK;
      end
      S_PEEK: peek_nxt = (|dv_q_r[63:32]) ? U32_MAX : dv_q_r[31:0];
      S_DONE: load_out = !out_valid_r || out_ch.ready;
      S_DIV: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_win_r <= INITIAL_WINDOW_RST;
      norm_win_r <= NORMAL_WINDOW_RST;
      base_scale_r <= SCALE_RST;
      small_scale_r <= SCALE_RST;
      low_scale_r <= SCALE_RST;
      cap_r <= 24'd0;
      floor_r <= 24'd0;
      small_bytes_r <= 16'd0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_idx_t'(cfg_ch.index))
        CFG_INITIAL_WINDOW: init_win_r <= cfg_ch.data[9:0];
        CFG_NORMAL_WINDOW:  norm_win_r <= cfg_ch.data[9:0];
        CFG_BASE_SCALE:     base_scale_r <= cfg_ch.data[15:0];
        CFG_SMALL_SCALE:    small_scale_r <= cfg_ch.data[15:0];
        CFG_LOW_USE_SCALE:  low_scale_r <= cfg_ch.data[15:0];
        CFG_SYMMETRY_CAP:   cap_r <= cfg_ch.data;
        CFG_FLOOR:          floor_r <= cfg_ch.data;
        CFG_SMALL_BYTES:    small_bytes_r <= cfg_ch.data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      last_valid_r <= 1'b0;
      last_time_r <= 32'd0;
      bytes_r <= 32'd0;
      elapsed_r <= 11'd0;
      have_est_r <= 1'b0;
      est_r <= 32'd0;
      var_r <= VAR_RST;
      dv_cnt_r <= 7'd0;
      dv_ret_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_valid_r <= last_valid_nxt;
      last_time_r <= last_time_nxt;
      bytes_r <= bytes_nxt;
      elapsed_r <= elapsed_nxt;
      have_est_r <= have_est_nxt;
      est_r <= est_nxt;
      var_r <= var_nxt;
      if (dv_go) begin
        dv_cnt_r <= dv_cnt_ld;
        dv_ret_r <= dv_ret_ld;
      end else if (state_r == S_DIV) begin
        dv_cnt_r <= dv_cnt_r - 7'd1;
      end
      if (load_out) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r <= in_ch.func;
      now_r <= in_ch.now_ms;
      bin_r <= in_ch.byte_count;
      low_use_r <= in_ch.in_low_usage;
    end
    win_r <= win_nxt;
    sample_r <= sample_nxt;
    small_r <= small_nxt;
    rate_r <= rate_nxt;
    below_r <= below_nxt;
    scale_r <= scale_nxt;
    diff_r <= diff_nxt;
    den_r <= den_nxt;
    svar_r <= svar_nxt;
    pred_r <= pred_nxt;
    dsum_r <= dsum_nxt;
    peek_r <= peek_nxt;
    if (mul_en) prod_r <= mul_a * mul_b;
    if (dv_go) begin
      dv_num_r <= dv_num_ld;
      dv_den_r <= dv_den_ld;
      dv_rem_r <= 34'd0;
      dv_q_r <= 64'd0;
    end else if (state_r == S_DIV) begin
      dv_num_r <= {dv_num_r[62:0], 1'b0};
      dv_rem_r <= rem_new;
      dv_q_r <= {dv_q_r[62:0], dv_ge};
    end
    if (load_out) begin
      out_est_valid_r <= have_est_r;
      out_est_r <= have_est_r ? est_r : 32'd0;
      out_sample_r <= sample_r;
      out_peek_valid_r <= (elapsed_r != 11'd0);
      out_peek_r <= peek_r;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.estimate_valid = out_est_valid_r;
  assign out_ch.estimate_kbps = out_est_r;
  assign out_ch.sample_taken = out_sample_r;
  assign out_ch.peek_valid = out_peek_valid_r;
  assign out_ch.peek_bytes_per_sec = out_peek_r;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_TIME)) else $error("item accepted but sequencer not started");
  a_est_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    !$fell(have_est_r)) else $error("estimate valid dropped");
  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (dv_cnt_r != 7'd0)) else $error("divider ran with zero count");
  a_floor_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_VDIV) |-> (est_r >= fl_q8)) else $error("estimate below floor");
`endif

endmodule

// ===== sim/tb_windowed_bitrate_bayes_estimator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_windowed_bitrate_bayes_estimator_top
// Self-checking bench for the windowed bitrate estimator: a scoreboard class
// predicts the estimate and window peek of every accepted item, and random
// packet reports and hints run under several register settings and idle mixes.
// ----------------------------------------------------------------------------
module tb_windowed_bitrate_bayes_estimator_top;
  import wbbe_pkg::*;

  typedef struct packed {
    logic        estimate_valid;
    logic [31:0] estimate_kbps;
    logic        sample_taken;
    logic        peek_valid;
    logic [31:0] peek_bytes_per_sec;
  } estimate_t;

  class bitrate_scoreboard;
    bit [9:0]  init_win, norm_win;
    bit [15:0] base_sc, small_sc, low_sc, small_bytes;
    bit [23:0] sym_cap, floor_k;
    bit        time_ok, have_est;
    bit [31:0] last_ms, win_bytes, est_q8, var_q16;
    bit [10:0] win_ms;
    estimate_t pending[$];
    int        mismatches;

    function new();
      init_win = INITIAL_WINDOW_RST; norm_win = NORMAL_WINDOW_RST;
      base_sc = SCALE_RST; small_sc = SCALE_RST; low_sc = SCALE_RST;
      small_bytes = 0; sym_cap = 0; floor_k = 0;
      time_ok = 0; have_est = 0; last_ms = 0; win_bytes = 0; win_ms = 0;
      est_q8 = 0; var_q16 = VAR_RST; mismatches = 0;
    endfunction

    function bit [31:0] sat32(bit [63:0] v);
      return (v > 64'hFFFF_FFFF) ? U32_MAX : v[31:0];
    endfunction

    function void set_reg(cfg_idx_t idx, bit [23:0] v);
      case (idx)
        CFG_INITIAL_WINDOW: init_win = v[9:0];
        CFG_NORMAL_WINDOW:  norm_win = v[9:0];
        CFG_BASE_SCALE:     base_sc = v[15:0];
        CFG_SMALL_SCALE:    small_sc = v[15:0];
        CFG_LOW_USE_SCALE:  low_sc = v[15:0];
        CFG_SYMMETRY_CAP:   sym_cap = v;
        CFG_FLOOR:          floor_k = v;
        CFG_SMALL_BYTES:    small_bytes = v[15:0];
        default: ;
      endcase
    endfunction

    function void note(bit f, bit [31:0] now, bit [15:0] nbytes, bit low);
      bit [63:0] w, e, c, est, r, scale, diff, cap, den, svar, u, pred, d, ne, fl;
      bit [31:0] rate;
      bit        smpl, sm, below;
      estimate_t x;
      smpl = 0; sm = 0; rate = 0;
      if (f == FUNC_HINT) begin
        var_q16 = sat32({32'b0, var_q16} + HINT_ADD);
      end else begin
        w = have_est ? norm_win : init_win;
        if (w < WIN_MIN) w = WIN_MIN;
        if (w > WIN_MAX) w = WIN_MAX;
        if (time_ok) begin
          if (now < last_ms) begin
            time_ok = 0; win_bytes = 0; win_ms = 0;
          end else begin
            e = now - last_ms;
            c = win_ms + e;
            if (e > w) begin
              win_bytes = 0;
              c = c % w;
            end
            win_ms = c[10:0];
          end
        end
        last_ms = now;
        time_ok = 1;
        if (win_ms >= w) begin
          sm = win_bytes < small_bytes;
          rate = sat32(({32'b0, win_bytes} * 64'd2048) / w);
          win_ms = win_ms - w[10:0];
          win_bytes = 0;
          smpl = 1;
        end
        win_bytes = sat32({32'b0, win_bytes} + nbytes);
        if (smpl && !have_est) begin
          est_q8 = rate;
          have_est = 1;
        end else if (smpl) begin
          est = est_q8; r = rate;
          below = r < est;
          scale = base_sc;
          if (sm && below) scale = small_sc;
          else if (low && below) scale = low_sc;
          diff = below ? est - r : r - est;
          cap = {40'b0, sym_cap} << 8;
          den = est + ((r < cap) ? r : cap);
          if (den == 0) begin
            svar = (diff == 0) ? 64'd0 : 64'hFFFF_FFFF;
          end else begin
            u = (scale * diff * 64'd256) / den;
            if (u > 64'hFF_FFFF) svar = 64'hFFFF_FFFF;
            else svar = (u * u) >> 16;
            if (svar > 64'hFFFF_FFFF) svar = 64'hFFFF_FFFF;
          end
          pred = sat32({32'b0, var_q16} + PRED_ADD);
          d = svar + pred;
          if (est >= r) ne = r + (svar * (est - r)) / d;
          else ne = est + (pred * (r - est)) / d;
          fl = {40'b0, floor_k} << 8;
          if (ne < fl) ne = fl;
          est_q8 = sat32(ne);
          var_q16 = sat32((svar * pred) / d);
        end
      end
      x.estimate_valid = have_est;
      x.estimate_kbps = have_est ? est_q8 : 32'd0;
      x.sample_taken = smpl;
      x.peek_valid = win_ms > 0;
      x.peek_bytes_per_sec = (win_ms > 0) ?
          sat32(({32'b0, win_bytes} * 64'd1000) / win_ms) : 32'd0;
      pending.push_back(x);
    endfunction

    function void check(estimate_t got);
      estimate_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %p", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got.estimate_valid !== exp_r.estimate_valid ||
          got.estimate_kbps !== exp_r.estimate_kbps ||
          got.sample_taken !== exp_r.sample_taken ||
          got.peek_valid !== exp_r.peek_valid ||
          got.peek_bytes_per_sec !== exp_r.peek_bytes_per_sec) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch at %0t: expected ev=%0b est=%h st=%0b pv=%0b peek=%h,",
                    " got ev=%0b est=%h st=%0b pv=%0b peek=%h"},
                   $realtime, exp_r.estimate_valid, exp_r.estimate_kbps,
                   exp_r.sample_taken, exp_r.peek_valid, exp_r.peek_bytes_per_sec,
                   got.estimate_valid, got.estimate_kbps, got.sample_taken,
                   got.peek_valid, got.peek_bytes_per_sec);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  wbbe_in_if  in_ch();
  wbbe_out_if out_ch();
  wbbe_cfg_if cfg_ch();

  windowed_bitrate_bayes_estimator_top DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  bitrate_scoreboard sb = new();
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        hold_left = 0;
  int        quiet_cycles = 0;
  bit [31:0] t_cursor = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: check, then pick next ready
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check({out_ch.estimate_valid, out_ch.estimate_kbps, out_ch.sample_taken,
                out_ch.peek_valid, out_ch.peek_bytes_per_sec});
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 20000) begin
      $display("tb_windowed_bitrate_bayes_estimator_top: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(bit f, bit [31:0] now, bit [15:0] nbytes, bit low);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= f;
    in_ch.now_ms <= now;
    in_ch.byte_count <= nbytes;
    in_ch.in_low_usage <= low;
    do @(posedge clk); while (!in_ch.ready);
    sb.note(f, now, nbytes, low);
  endtask

  task automatic report(bit [31:0] now, bit [15:0] nbytes, bit low);
    t_cursor = now;
    send_item(FUNC_REPORT, now, nbytes, low);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, bit [23:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  task automatic load_setting(bit [9:0] iw, bit [9:0] nw, bit [15:0] bs, bit [15:0] ss,
                              bit [15:0] ls, bit [23:0] cap, bit [23:0] fl, bit [15:0] sb_n);
    write_reg(CFG_INITIAL_WINDOW, 24'(iw));
    write_reg(CFG_NORMAL_WINDOW, 24'(nw));
    write_reg(CFG_BASE_SCALE, 24'(bs));
    write_reg(CFG_SMALL_SCALE, 24'(ss));
    write_reg(CFG_LOW_USE_SCALE, 24'(ls));
    write_reg(CFG_SYMMETRY_CAP, cap);
    write_reg(CFG_FLOOR, fl);
    write_reg(CFG_SMALL_BYTES, 24'(sb_n));
    @(posedge clk);
  endtask

  // mostly forward time with random content, some gaps, jumps back and wild times
  task automatic random_items(int n);
    int        pick;
    bit [15:0] nb;
    repeat (n) begin
      pick = $urandom_range(99);
      case ($urandom_range(3))
        0: nb = 16'd0;
        1: nb = 16'hFFFF;
        default: nb = 16'($urandom);
      endcase
      if (pick < 10) send_item(FUNC_HINT, $urandom, 16'($urandom), 1'($urandom));
      else if (pick < 14) report(t_cursor - $urandom_range(1, 2000), nb, 1'($urandom));
      else if (pick < 19) report(t_cursor + $urandom_range(1001, 5000), nb, 1'($urandom));
      else if (pick < 22) report($urandom, nb, 1'($urandom));
      else report(t_cursor + $urandom_range(0, 90), nb, 1'($urandom));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0; in_ch.func = FUNC_REPORT; in_ch.now_ms = '0;
    in_ch.byte_count = '0; in_ch.in_low_usage = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.index = CFG_INITIAL_WINDOW; cfg_ch.data = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: defaults except the small-sample byte threshold and the low-use scale
    write_reg(CFG_SMALL_BYTES, 24'd2000);
    write_reg(CFG_LOW_USE_SCALE, 24'd512);
    send_item(FUNC_HINT, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    report(32'd0, 16'hFFFF, 1'b1);
    report(32'd100, 16'd0, 1'b0);
    report(32'd600, 16'd0, 1'b0);      // first window closes, estimate appears
    report(32'd700, 16'd1000, 1'b0);
    report(32'd760, 16'd0, 1'b1);
    report(32'd800, 16'd500, 1'b1);
    report(32'd960, 16'd0, 1'b1);      // small sample below estimate
    report(32'd10, 16'd300, 1'b0);     // time goes backwards
    report(32'd5000, 16'd40000, 1'b0); // gap longer than window
    report(32'd5150, 16'hFFFF, 1'b0);
    report(32'd5300, 16'd0, 1'b0);
    send_item(FUNC_HINT, 32'd0, 16'd0, 1'b0);
    report(32'hFFFF_FFF0, 16'd1, 1'b1);
    report(32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    report(32'd0, 16'd0, 1'b0);
    report(32'd150, 16'd0, 1'b0);
    report(32'd300, 16'd0, 1'b0);       // zero rate against estimate
    drain();

    // phase 1: no idling, out-of-range windows clamp to the low end
    load_setting(10'd0, 10'd149, 16'd0, 16'd0, 16'd0, 24'd0, 24'd0, 16'd0);
    t_cursor = 0;
    random_items(30);
    drain();

    // phase 2: sender mostly idle, long receiver hold-off at the start
    load_setting(10'd1000, 10'd1000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFF_FFFF,
                 24'd0, 16'hFFFF);
    send_idle_pct = 79;
    hold_left = 600;
    random_items(30);
    drain();

    // phase 3: receiver mostly stalling
    send_idle_pct = 0; recv_stall_pct = 79;
    load_setting(10'd1023, 10'd300, 16'd2560, 16'd700, 16'd40000, 24'd500,
                 24'hFF_FFFF, 16'd20000);
    random_items(30);
    drain();

    // phase 4: both sides idle, then enough hints to saturate the variance
    send_idle_pct = 36; recv_stall_pct = 36;
    load_setting(10'd150, 10'd150, 16'd256, 16'd4096, 16'd1024, 24'd3000,
                 24'd100, 16'd5000);
    random_items(10);
    repeat (330) send_item(FUNC_HINT, $urandom, 16'($urandom), 1'($urandom));
    random_items(10);
    drain();
    repeat (400) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("tb_windowed_bitrate_bayes_estimator_top: PASS");
    end else begin
      $display("tb_windowed_bitrate_bayes_estimator_top: FAIL");
    end
    $finish;
  end

endmodule
